// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the pool RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FBP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pool assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define FBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pool assertion failed");

`endif

// ===== hw/rtl/fbp_pkg.sv =====
// ---------------------------------------------------------------------------
// fbp_pkg
// Types, codes and constants shared by the fixed block free list pool.
// ---------------------------------------------------------------------------
package fbp_pkg;

  // Default depth of the link table.
  localparam int unsigned MAX_BLOCKS_DEF = 256;

  // Field widths.
  localparam int unsigned IDX_W = 8;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned STS_W = 2;

  // Counters saturate at their all-ones value.
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration port.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [CNT_W-1:0] POOL_BLOCKS_RST = 9'd256;

  // Command codes of an input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT = 2'd0,
    CMD_GET  = 2'd1,
    CMD_FREE = 2'd2
  } cmd_e;

  // Status codes of a result item.
  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_BAD   = 2'd2
  } sts_e;

  // Register indexes of the configuration port.
  typedef enum logic [0:0] {
    REG_POOL_BLOCKS = 1'b0
  } reg_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_GET,
    ST_RESP
  } state_e;

  // Input item.
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] block_index;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [IDX_W-1:0] granted_index;
    logic [CNT_W-1:0] blocks_in_use;
    logic [CNT_W-1:0] peak_in_use;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic init_step;
    logic get_wb;
    logic load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             head_present;
    logic             pool_empty;
    logic             init_last;
    logic             out_free;
  } ctl_sts_t;

endpackage

// ===== hw/rtl/fixed_block_free_list_pool.sv =====
// ---------------------------------------------------------------------------
// fixed_block_free_list_pool
// Fixed-size block allocator with a LIFO free list of block indices.
// ---------------------------------------------------------------------------
// One item is handled at a time. The result of a free, an empty get or an
// invalid command is loaded into the output register in ST_RESP, which
// follows ST_IDLE, where the item is accepted. A successful get passes
// through ST_GET first because the link of the head comes from the
// synchronous read port of the link table, and an init passes through
// ST_INIT, writing one link table entry per cycle for pool_blocks entries
// (pool_blocks clipped to MAX_BLOCKS). A new item is accepted in the cycle
// after the previous result is loaded into the output register; a result
// waits only if the one before it has not yet been taken. The link table
// needs no clearing pass after reset: the list is empty until the first init.
// ---------------------------------------------------------------------------
module fixed_block_free_list_pool #(
  parameter int unsigned MAX_BLOCKS = fbp_pkg::MAX_BLOCKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input items
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  fbp_pkg::in_item_t            in_item_i,
  // Result items
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output fbp_pkg::out_item_t           out_item_o,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fbp_pkg::APB_AW-1:0]   paddr,
  input  logic [fbp_pkg::APB_DW-1:0]   pwdata,
  output logic [fbp_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import fbp_pkg::*;

  logic [CNT_W-1:0] pool_blocks_q;
  logic             reg_idx;
  logic             reg_wr;
  ctl_cmd_t         cmd;
  ctl_sts_t         sts;

  // Register decode: paddr[2] selects the 32-bit register word.
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_blocks_q <= POOL_BLOCKS_RST;
    end else if (reg_wr && reg_idx == REG_POOL_BLOCKS) begin
      pool_blocks_q <= pwdata[CNT_W-1:0];
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      REG_POOL_BLOCKS: prdata = APB_DW'(pool_blocks_q);
      default:         prdata = '0;
    endcase
  end

  fbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fbp_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_item_i     (in_item_i),
    .pool_blocks_i (pool_blocks_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .out_item_o    (out_item_o)
  );

endmodule

// ===== hw/rtl/fbp_ram.sv =====
// ---------------------------------------------------------------------------
// fbp_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module fbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fbp_ctrl.sv =====
// ---------------------------------------------------------------------------
// fbp_ctrl
// Controller state machine: accepts an item, sequences the init sweep or
// the get writeback, and hands the result to the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fbp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fbp_pkg::ctl_sts_t  sts_i,
  output fbp_pkg::ctl_cmd_t  cmd_o
);
  import fbp_pkg::*;

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.command == CMD_INIT && !sts_i.pool_empty) begin
            state_d = ST_INIT;
          end else if (sts_i.command == CMD_GET && sts_i.head_present) begin
            state_d = ST_GET;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_INIT: begin
        if (sts_i.init_last) begin
          state_d = ST_RESP;
        end
      end
      ST_GET: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_INIT: begin
        cmd_o.init_step = 1'b1;
      end
      ST_GET: begin
        cmd_o.get_wb = 1'b1;
      end
      ST_RESP: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A get that finds a block must write back the popped link next cycle.
  `FBP_ASSERT_NEXT(a_get_wb_follows, cmd_o.accept && sts_i.command == CMD_GET && sts_i.head_present, cmd_o.get_wb)

endmodule

// ===== hw/rtl/fbp_dp.sv =====
// ---------------------------------------------------------------------------
// fbp_dp
// Datapath: free list head, link table, use and peak counters, init
// sweep counter and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fbp_dp #(
  parameter int unsigned MAX_BLOCKS = fbp_pkg::MAX_BLOCKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fbp_pkg::in_item_t           in_item_i,
  input  logic [fbp_pkg::CNT_W-1:0]   pool_blocks_i,
  input  fbp_pkg::ctl_cmd_t           cmd_i,
  output fbp_pkg::ctl_sts_t           sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output fbp_pkg::out_item_t          out_item_o
);
  import fbp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned LW = IDX_W + 1;

  logic [IDX_W-1:0] head_q, head_d;
  logic             head_present_q, head_present_d;
  logic [CNT_W-1:0] use_q, use_d;
  logic [CNT_W-1:0] peak_q, peak_d;
  logic [CNT_W-1:0] init_cnt_q, init_cnt_d;
  logic [STS_W-1:0] status_q, status_d;
  logic [IDX_W-1:0] granted_q, granted_d;
  logic             out_valid_q;
  out_item_t        out_item_q;

  logic [CNT_W-1:0] eff_n;
  logic [CNT_W-1:0] init_nxt;
  logic             init_last;
  logic             free_ok;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [LW-1:0]    ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [LW-1:0]    ram_rdata;

  // Pool size clipped to the table depth.
  assign eff_n = (32'(pool_blocks_i) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : pool_blocks_i;

  // Init sweep position and its last entry.
  assign init_nxt  = init_cnt_q + 9'd1;
  assign init_last = (init_cnt_q == eff_n - 9'd1);

  // A free is taken only for a block inside the pool while blocks are out.
  assign free_ok = ({1'b0, in_item_i.block_index} < eff_n) && (use_q != '0);

  // Link table write: init sweep or push on free.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(in_item_i.block_index);
    ram_wdata = {head_present_q, head_q};
    if (cmd_i.init_step) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(init_cnt_q);
      ram_wdata = init_last ? '0 : {1'b1, IDX_W'(init_nxt)};
    end else if (cmd_i.accept && in_item_i.command == CMD_FREE && free_ok) begin
      ram_we = 1'b1;
    end
  end

  // Link table read of the head on a get.
  assign ram_re    = cmd_i.accept && (in_item_i.command == CMD_GET) && head_present_q;
  assign ram_raddr = AW'(head_q);

  fbp_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // List head and counters.
  always_comb begin
    head_d         = head_q;
    head_present_d = head_present_q;
    use_d          = use_q;
    peak_d         = peak_q;
    init_cnt_d     = init_cnt_q;
    if (cmd_i.accept) begin
      case (in_item_i.command)
        CMD_INIT: begin
          head_d         = '0;
          head_present_d = (eff_n != '0);
          use_d          = '0;
          peak_d         = '0;
          init_cnt_d     = '0;
        end
        CMD_FREE: begin
          if (free_ok) begin
            head_d         = in_item_i.block_index;
            head_present_d = 1'b1;
            use_d          = use_q - 9'd1;
          end
        end
        default: begin
          head_d = head_q;
        end
      endcase
    end else if (cmd_i.init_step) begin
      init_cnt_d = init_nxt;
    end else if (cmd_i.get_wb) begin
      head_d         = ram_rdata[IDX_W-1:0];
      head_present_d = ram_rdata[IDX_W];
      use_d          = (use_q != CNT_MAX) ? use_q + 9'd1 : use_q;
      peak_d         = (use_d > peak_q) ? use_d : peak_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q         <= '0;
      head_present_q <= 1'b0;
      use_q          <= '0;
      peak_q         <= '0;
      init_cnt_q     <= '0;
    end else begin
      head_q         <= head_d;
      head_present_q <= head_present_d;
      use_q          <= use_d;
      peak_q         <= peak_d;
      init_cnt_q     <= init_cnt_d;
    end
  end

  // Status and granted index, decided when the item is accepted.
  always_comb begin
    status_d  = status_q;
    granted_d = granted_q;
    if (cmd_i.accept) begin
      granted_d = '0;
      case (in_item_i.command)
        CMD_INIT: begin
          status_d = STS_OK;
        end
        CMD_GET: begin
          if (head_present_q) begin
            status_d  = STS_OK;
            granted_d = head_q;
          end else begin
            status_d = STS_EMPTY;
          end
        end
        CMD_FREE: begin
          status_d = free_ok ? STS_OK : STS_BAD;
        end
        default: begin
          status_d = STS_BAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    granted_q <= granted_d;
  end

  // Result register, loaded when the slot is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_item_q.status        <= status_q;
      out_item_q.granted_index <= granted_q;
      out_item_q.blocks_in_use <= use_q;
      out_item_q.peak_in_use   <= peak_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Status to the controller.
  assign sts_o.command      = in_item_i.command;
  assign sts_o.head_present = head_present_q;
  assign sts_o.pool_empty   = (eff_n == '0);
  assign sts_o.init_last    = init_last;
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  // The peak never falls below the current count.
  `FBP_ASSERT(a_peak_ge_use, peak_q >= use_q)

  // A taken free makes the returned block the new head.
  `FBP_ASSERT_NEXT(a_free_push, cmd_i.accept && in_item_i.command == CMD_FREE && free_ok, head_present_q && head_q == $past(in_item_i.block_index))

  // A get writeback raises the count by one unless it is saturated.
  `FBP_ASSERT_NEXT(a_get_count, cmd_i.get_wb && use_q != CNT_MAX, use_q == $past(use_q) + 9'd1)

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for fixed_block_free_list_pool
// Drives init, get, free and invalid commands with random gaps on both
// handshakes. A local model of the free list predicts every result, and the
// monitor compares each result field by field.
// ----------------------------------------------------------------------------
module tb;
  import fbp_pkg::*;

  localparam int unsigned NUM_BLOCKS = MAX_BLOCKS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [APB_AW-1:0] POOL_BLOCKS_ADDR = APB_AW'(4 * int'(REG_POOL_BLOCKS));
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned RANDOM_REQUESTS = 200;
  localparam int unsigned SATURATING_GETS = 515;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  // Free list model: links, head, counters and the pool size register.
  logic [IDX_W-1:0] next_link [NUM_BLOCKS];
  logic next_valid [NUM_BLOCKS];
  logic [IDX_W-1:0] free_head;
  logic free_head_valid;
  logic [CNT_W-1:0] in_use_count;
  logic [CNT_W-1:0] peak_count;
  logic [CNT_W-1:0] pool_blocks_cfg;

  in_item_t requests_to_send[$];
  out_item_t pool_replies_due[$];
  int unsigned held_blocks[$];

  int errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned ready_hold = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  bit quiet_phase = 1'b0;

  fixed_block_free_list_pool #(
    .MAX_BLOCKS(NUM_BLOCKS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o(out_item_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_phase || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Applies one command to the free list model and returns its result.
  function automatic out_item_t predict_pool_reply(input in_item_t req);
    out_item_t reply;
    int unsigned n;
    int unsigned idx;
    n = (32'(pool_blocks_cfg) > NUM_BLOCKS) ? NUM_BLOCKS : 32'(pool_blocks_cfg);
    idx = 32'(req.block_index);
    reply = '0;
    reply.status = STS_OK;
    case (req.command)
      CMD_INIT: begin
        for (int unsigned i = 0; i < n; i++) begin
          next_link[IDX_W'(i)] = (i + 1 < n) ? IDX_W'(i + 1) : '0;
          next_valid[IDX_W'(i)] = (i + 1 < n);
        end
        free_head = '0;
        free_head_valid = (n > 0);
        in_use_count = '0;
        peak_count = '0;
      end
      CMD_GET: begin
        if (!free_head_valid) begin
          reply.status = STS_EMPTY;
        end else begin
          reply.granted_index = free_head;
          free_head_valid = next_valid[free_head];
          free_head = next_link[free_head];
          if (in_use_count != CNT_MAX) in_use_count = in_use_count + 1'b1;
          if (in_use_count > peak_count) peak_count = in_use_count;
        end
      end
      CMD_FREE: begin
        if (idx >= n || in_use_count == '0) begin
          reply.status = STS_BAD;
        end else begin
          // Push the block; a block freed twice simply appears twice.
          next_link[IDX_W'(idx)] = free_head;
          next_valid[IDX_W'(idx)] = free_head_valid;
          free_head = IDX_W'(idx);
          free_head_valid = 1'b1;
          in_use_count = in_use_count - 1'b1;
        end
      end
      default: begin
        reply.status = STS_BAD;
      end
    endcase
    reply.blocks_in_use = in_use_count;
    reply.peak_in_use = peak_count;
    return reply;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Driver: offers queued items and predicts each accepted one.
  always @(posedge clk_i) begin : drive_requests
    out_item_t reply;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        reply = predict_pool_reply(in_item_i);
        pool_replies_due.push_back(reply);
        // Keep track of handed-out blocks so that frees can return them.
        if (in_item_i.command == CMD_INIT) begin
          held_blocks.delete();
        end else if (in_item_i.command == CMD_GET && reply.status == STS_OK) begin
          held_blocks.push_back(32'(reply.granted_index));
        end else if (in_item_i.command == CMD_FREE && reply.status == STS_OK) begin
          for (int i = 0; i < held_blocks.size(); i++) begin
            if (held_blocks[i] == 32'(in_item_i.block_index)) begin
              held_blocks.delete(i);
              break;
            end
          end
        end
        send_gap = pick_gap();
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (requests_to_send.size() > 0) begin
          in_item_i <= requests_to_send.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result and throttles the result channel.
  always @(posedge clk_i) begin : check_replies
    out_item_t want;
    bit taken;
    taken = out_valid_o && out_ready_i;
    if (taken) begin
      if (pool_replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_item_o);
      end else begin
        want = pool_replies_due.pop_front();
        check_field("status", 32'(want.status), 32'(out_item_o.status));
        check_field("granted_index", 32'(want.granted_index),
                    32'(out_item_o.granted_index));
        check_field("blocks_in_use", 32'(want.blocks_in_use),
                    32'(out_item_o.blocks_in_use));
        check_field("peak_in_use", 32'(want.peak_in_use), 32'(out_item_o.peak_in_use));
      end
    end
    if (rst_ni) begin
      if (hold_requests != holds_served) begin
        holds_served++;
        ready_hold = LONG_HOLD;
      end else if (ready_hold == 0 && (taken || $urandom_range(0, 7) == 0)) begin
        ready_hold = pick_gap();
      end
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel || !rst_ni) begin
      quiet_cycles = 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
    in_item_t req;
    req.command = cmd;
    req.block_index = idx;
    requests_to_send.push_back(req);
  endtask

  // Waits until every item is sent and every result has come back.
  // The check runs at the falling edge, after the clocked blocks have settled.
  task automatic drain_pool();
    while (requests_to_send.size() > 0 || in_valid_i || pool_replies_due.size() > 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the pool size register, then reads it back.
  task automatic set_pool_size(input logic [CNT_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= POOL_BLOCKS_ADDR;
    pwdata <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pool_blocks_cfg = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("pool_blocks readback", 32'(pool_blocks_cfg), 32'(prdata[CNT_W-1:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random burst: mostly gets and frees of held blocks, some noise.
  task automatic queue_random_burst(input int unsigned count);
    int unsigned avail[$];
    int unsigned roll;
    int unsigned pick;
    avail = held_blocks;
    for (int unsigned k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        queue_request(CMD_GET, IDX_W'($urandom));
      end else if (roll < 80 && avail.size() > 0) begin
        pick = $urandom_range(0, avail.size() - 1);
        queue_request(CMD_FREE, IDX_W'(avail[pick]));
        avail.delete(pick);
      end else if (roll < 92) begin
        queue_request(CMD_FREE, IDX_W'($urandom));
      end else if (roll < 96) begin
        queue_request(CMD_INIT, IDX_W'($urandom));
      end else begin
        queue_request(CMD_UNKNOWN, IDX_W'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned roll;
    int unsigned round;
    logic [CNT_W-1:0] size;

    for (int i = 0; i < NUM_BLOCKS; i++) begin
      next_link[IDX_W'(i)] = '0;
      next_valid[IDX_W'(i)] = 1'b0;
    end
    free_head = '0;
    free_head_valid = 1'b0;
    in_use_count = '0;
    peak_count = '0;
    pool_blocks_cfg = POOL_BLOCKS_RST;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset size: commands before init, then gets, frees and a double free.
    queue_request(CMD_GET, 8'd0);
    queue_request(CMD_FREE, 8'd0);
    queue_request(CMD_UNKNOWN, 8'd255);
    queue_request(CMD_INIT, 8'd255);
    queue_request(CMD_GET, 8'd0);
    queue_request(CMD_GET, 8'd0);
    queue_request(CMD_FREE, 8'd255);
    queue_request(CMD_FREE, 8'd0);
    queue_request(CMD_FREE, 8'd7);
    queue_request(CMD_GET, 8'd0);
    queue_request(CMD_GET, 8'd0);
    queue_request(CMD_GET, 8'd0);
    queue_request(CMD_FREE, 8'd1);
    queue_request(CMD_FREE, 8'd1);
    queue_request(CMD_GET, 8'd0);
    queue_request(CMD_GET, 8'd0);
    drain_pool();

    // Empty pool after an init with size zero.
    set_pool_size(9'd0);
    queue_request(CMD_INIT, 8'd0);
    queue_request(CMD_GET, 8'd0);
    queue_request(CMD_FREE, 8'd0);
    drain_pool();

    // Oversized pool clipped to the table depth.
    set_pool_size(9'd511);
    queue_request(CMD_INIT, 8'd0);
    queue_request(CMD_GET, 8'd0);
    queue_request(CMD_FREE, 8'd255);
    drain_pool();

    // Single-block pool: empty get and out-of-range free.
    set_pool_size(9'd1);
    queue_request(CMD_INIT, 8'd0);
    queue_request(CMD_GET, 8'd0);
    queue_request(CMD_GET, 8'd0);
    queue_request(CMD_FREE, 8'd1);
    queue_request(CMD_FREE, 8'd0);
    queue_request(CMD_FREE, 8'd0);
    drain_pool();

    // Random bursts, with the pool resized and reinitialized now and then.
    sent = 0;
    round = 0;
    while (sent < RANDOM_REQUESTS) begin
      if (round % 4 == 0) begin
        roll = $urandom_range(0, 9);
        case (roll)
          0: size = 9'd1;
          1: size = 9'd256;
          2: size = 9'd0;
          3: size = CNT_W'($urandom_range(257, 511));
          4, 5: size = CNT_W'($urandom_range(1, 256));
          default: size = CNT_W'($urandom_range(2, 12));
        endcase
        set_pool_size(size);
        queue_request(CMD_INIT, IDX_W'($urandom));
        sent++;
      end
      quiet_phase = ($urandom_range(0, 4) == 0);
      burst = $urandom_range(15, 40);
      // Hold off the result channel once while items keep coming.
      if (round == 2) hold_requests++;
      queue_random_burst(burst);
      sent += burst;
      round++;
      drain_pool();
    end

    // A doubly freed block forms a loop, so gets run the count to saturation.
    quiet_phase = 1'b0;
    set_pool_size(9'd4);
    queue_request(CMD_INIT, 8'd0);
    repeat (4) queue_request(CMD_GET, 8'd0);
    queue_request(CMD_FREE, 8'd3);
    queue_request(CMD_FREE, 8'd3);
    repeat (SATURATING_GETS) queue_request(CMD_GET, IDX_W'($urandom));
    queue_request(CMD_FREE, 8'd3);
    queue_request(CMD_FREE, 8'd2);
    queue_request(CMD_GET, 8'd0);
    queue_request(CMD_INIT, 8'd0);
    queue_request(CMD_GET, 8'd0);
    drain_pool();

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/fbp_pkg.sv
hw/rtl/fbp_ram.sv
hw/rtl/fbp_ctrl.sv
hw/rtl/fbp_dp.sv
hw/rtl/fixed_block_free_list_pool.sv
test/tb.sv
